// ----- rtl/first_fit_heap_allocator_assert.svh -----
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffha check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffha check failed");

`endif

// ----- rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_ALLOCATED    = 3'd0;
  localparam status_t ST_ZERO_SIZE    = 3'd1;
  localparam status_t ST_NO_SPACE     = 3'd2;
  localparam status_t ST_TABLE_FULL   = 3'd3;
  localparam status_t ST_FREED        = 3'd4;
  localparam status_t ST_FREE_IGNORED = 3'd5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_HEAP_BYTES   = 1'b1;

  localparam logic [20:0] HEAP_BYTES_RESET = 21'd1048576;

endpackage

// ----- rtl/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with coalescing, block table held in one RAM.
// ----------------------------------------------------------------------------
// One request at a time. The block table is walked through a single RAM read
// port, each entry read in S_ARD or S_FRD and checked in S_ACHK or S_FCHK. An
// allocate with no fit in the scanned entries tries to append at the bump
// pointer in S_APP. A free whose block is found checks the next neighbor and
// then the previous one for merging, and each merge shifts later entries down
// with a read and a write of each later entry. in_stall stays high from
// acceptance until the result beat has been taken. Configuration writes are
// accepted at any time but must only be issued while no request is in flight.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS     = 64,
  parameter int HEADER_BYTES   = 16,
  parameter int MAX_HEAP_BYTES = 1048576
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [20:0]           in_req_size,
  input  logic [31:0]           in_free_addr,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_result_addr,
  output ffha_pkg::status_t     out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data
);
  import ffha_pkg::*;

  localparam int OW = $clog2(MAX_HEAP_BYTES + 1);
  localparam int SW = (OW > 22) ? OW : 22;
  localparam int LW = SW + 2;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 1 + SW + OW;

  typedef struct packed {
    logic          is_free;
    logic [SW-1:0] size;
    logic [OW-1:0] start;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_ACHK, S_APP, S_FRD, S_FCHK, S_FNEXT, S_FNCHK,
    S_FPREV, S_PCHK, S_DRD, S_DWR, S_OUT
  } state_t;

  state_t        state_r;
  logic [31:0]   base_r;
  logic [20:0]   heap_r;
  logic [CW-1:0] count_r;
  logic [OW-1:0] bump_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] k_r;
  logic          drop_last_r;
  logic [SW-1:0] need_r;
  logic [31:0]   addr_r;
  logic [OW-1:0] cur_start_r;
  logic [SW-1:0] cur_size_r;
  logic [31:0]   res_addr_r;
  status_t       status_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        rd;

  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] k_p1;
  logic [31:0]   rd_paddr;
  logic          alloc_hit;
  logic [SW-1:0] merged_size;
  logic [SW-1:0] prev_merged;
  logic [LW-1:0] app_sum;
  logic [LW-1:0] limit;
  logic          app_fits;
  logic          tbl_full;
  logic [SW-1:0] need_nxt;

  assign rd          = entry_t'(ram_rdata);
  assign idx_p1      = idx_r + CW'(1);
  assign idx_m1      = idx_r - CW'(1);
  assign k_p1        = k_r + CW'(1);
  assign rd_paddr    = base_r + 32'(rd.start) + 32'(HEADER_BYTES);
  assign alloc_hit   = rd.is_free && (rd.size >= need_r);
  assign merged_size = SW'(cur_size_r + SW'(HEADER_BYTES) + rd.size);
  assign prev_merged = SW'(rd.size + SW'(HEADER_BYTES) + cur_size_r);
  assign app_sum     = LW'(bump_r) + LW'(need_r) + LW'(HEADER_BYTES);
  assign limit       = (LW'(heap_r) > LW'(MAX_HEAP_BYTES)) ? LW'(MAX_HEAP_BYTES)
                                                          : LW'(heap_r);
  assign app_fits    = (app_sum <= limit);
  assign tbl_full    = (count_r == CW'(MAX_BLOCKS));
  // round up to a multiple of 8
  assign need_nxt    = (SW'(in_req_size) + SW'(7)) & ~SW'(7);

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_result_addr = res_addr_r;
  assign out_status      = status_r;
  assign cfg_ready       = 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[IW-1:0];
    ram_wdata = '{is_free: 1'b1, size: cur_size_r, start: cur_start_r};
    ram_raddr = i_r[IW-1:0];
    unique case (state_r)
      S_ACHK: begin
        ram_waddr = i_r[IW-1:0];
        ram_wdata = '{is_free: 1'b0, size: rd.size, start: rd.start};
        ram_we    = alloc_hit;
      end
      S_APP: begin
        ram_waddr = count_r[IW-1:0];
        ram_wdata = '{is_free: 1'b0, size: need_r, start: bump_r};
        ram_we    = app_fits && !tbl_full;
      end
      S_FNEXT: begin
        ram_raddr = idx_p1[IW-1:0];
        ram_we    = !(idx_p1 < count_r);
      end
      S_FNCHK: begin
        ram_we    = 1'b1;
        ram_wdata = '{is_free: 1'b1,
                      size: rd.is_free ? merged_size : cur_size_r,
                      start: cur_start_r};
      end
      S_FPREV: ram_raddr = idx_m1[IW-1:0];
      S_PCHK: begin
        ram_waddr = idx_m1[IW-1:0];
        ram_wdata = '{is_free: 1'b1, size: prev_merged, start: rd.start};
        ram_we    = rd.is_free;
      end
      S_DRD: ram_raddr = k_p1[IW-1:0];
      S_DWR: begin
        ram_waddr = k_r[IW-1:0];
        ram_wdata = rd;
        ram_we    = 1'b1;
      end
      default: ;
    endcase
  end

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      base_r   <= '0;
      heap_r   <= HEAP_BYTES_RESET;
      count_r  <= '0;
      bump_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BASE_ADDRESS: base_r <= cfg_data;
          CFG_HEAP_BYTES:   heap_r <= cfg_data[20:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            need_r     <= need_nxt;
            addr_r     <= in_free_addr;
            i_r        <= '0;
            res_addr_r <= '0;
            if (in_cmd == CMD_ALLOC) begin
              if (in_req_size == '0) begin
                status_r <= ST_ZERO_SIZE;
                state_r  <= S_OUT;
              end else begin
                state_r <= S_ARD;
              end
            end else if (in_free_addr == '0) begin
              status_r <= ST_FREE_IGNORED;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_FRD;
            end
          end
        end
        S_ARD: state_r <= (i_r == count_r) ? S_APP : S_ACHK;
        S_ACHK: begin
          if (alloc_hit) begin
            res_addr_r <= rd_paddr;
            status_r   <= ST_ALLOCATED;
            state_r    <= S_OUT;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_ARD;
          end
        end
        S_APP: begin
          if (!app_fits) begin
            status_r <= ST_NO_SPACE;
          end else if (tbl_full) begin
            status_r <= ST_TABLE_FULL;
          end else begin
            res_addr_r <= base_r + 32'(bump_r) + 32'(HEADER_BYTES);
            status_r   <= ST_ALLOCATED;
            count_r    <= count_r + CW'(1);
            bump_r     <= OW'(app_sum);
          end
          state_r <= S_OUT;
        end
        S_FRD: begin
          if (i_r == count_r) begin
            status_r <= ST_FREE_IGNORED;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (rd_paddr == addr_r) begin
            idx_r       <= i_r;
            cur_start_r <= rd.start;
            cur_size_r  <= rd.size;
            state_r     <= S_FNEXT;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_FRD;
          end
        end
        S_FNEXT: state_r <= (idx_p1 < count_r) ? S_FNCHK : S_FPREV;
        S_FNCHK: begin
          if (rd.is_free) begin
            cur_size_r  <= merged_size;
            k_r         <= idx_p1;
            drop_last_r <= 1'b0;
            state_r     <= S_DRD;
          end else begin
            state_r <= S_FPREV;
          end
        end
        S_FPREV: begin
          if (idx_r != '0) begin
            state_r <= S_PCHK;
          end else begin
            status_r <= ST_FREED;
            state_r  <= S_OUT;
          end
        end
        S_PCHK: begin
          if (rd.is_free) begin
            k_r         <= idx_r;
            drop_last_r <= 1'b1;
            state_r     <= S_DRD;
          end else begin
            status_r <= ST_FREED;
            state_r  <= S_OUT;
          end
        end
        // shift later entries down by one over the dropped slot
        S_DRD: begin
          if (k_p1 < count_r) begin
            state_r <= S_DWR;
          end else begin
            count_r <= count_r - CW'(1);
            if (drop_last_r) begin
              status_r <= ST_FREED;
              state_r  <= S_OUT;
            end else begin
              state_r <= S_FPREV;
            end
          end
        end
        S_DWR: begin
          k_r     <= k_p1;
          state_r <= S_DRD;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the first-fit heap allocator.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [31:0]       out_result_addr,
  input ffha_pkg::status_t out_status
);
  import ffha_pkg::*;

  `FFHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `FFHA_ASSERT_NOW(a_status_range, out_valid, out_status <= ST_FREE_IGNORED)
  `FFHA_ASSERT_NOW(a_fail_addr_zero, out_valid && (out_status != ST_ALLOCATED),
                   out_result_addr == '0)
  `FFHA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `FFHA_ASSERT_NOW(a_one_in_flight, out_valid, in_stall)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

// ----- test/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Self-checking bench: directed corner beats, then random alloc/free traffic
// over several register settings and idle/stall phases, checked in order
// against a behavioral allocator table.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int NBLK = 64;
  localparam int HDR  = 16;
  localparam int MAXH = 1048576;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic [31:0] addr;
    status_t     status;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [31:0] base;
    logic [20:0] heap;
    int unsigned start[NBLK];
    int unsigned psize[NBLK];
    bit          is_free[NBLK];
    int unsigned count;
    int unsigned bump;
    alloc_result_t pending[$];
    int errors;

    function void clear();
      base = 0; heap = HEAP_BYTES_RESET; count = 0; bump = 0;
      pending.delete(); errors = 0;
    endfunction

    function void remove_entry(int unsigned idx);
      for (int unsigned k = idx; k + 1 < count; k++) begin
        start[k] = start[k+1]; psize[k] = psize[k+1]; is_free[k] = is_free[k+1];
      end
      count--;
    endfunction

    function logic [31:0] payload(int unsigned s);
      return base + s + HDR;
    endfunction

    function void note_request(logic cmd, logic [20:0] req, logic [31:0] fa);
      alloc_result_t r;
      int unsigned need, lim, i;
      bit done;
      r.addr = 0;
      done = 0;
      if (cmd == CMD_ALLOC) begin
        if (req == 0) r.status = ST_ZERO_SIZE;
        else begin
          need = (req + 7) & ~32'd7;
          for (i = 0; i < count && !done; i++)
            if (is_free[i] && psize[i] >= need) begin
              is_free[i] = 0; r.addr = payload(start[i]); r.status = ST_ALLOCATED;
              done = 1;
            end
          if (!done) begin
            lim = (heap > MAXH) ? MAXH : heap;
            if (longint'(bump) + need + HDR > lim) r.status = ST_NO_SPACE;
            else if (count >= NBLK) r.status = ST_TABLE_FULL;
            else begin
              start[count] = bump; psize[count] = need; is_free[count] = 0;
              count++;
              r.addr = payload(bump); r.status = ST_ALLOCATED;
              bump += need + HDR;
            end
          end
        end
      end else begin
        r.status = ST_FREE_IGNORED;
        if (fa != 0) begin
          for (i = 0; i < count; i++) if (payload(start[i]) == fa) break;
          if (i < count) begin
            is_free[i] = 1;
            if (i + 1 < count && is_free[i+1]) begin
              psize[i] += HDR + psize[i+1]; remove_entry(i + 1);
            end
            if (i > 0 && is_free[i-1]) begin
              psize[i-1] += HDR + psize[i]; remove_entry(i);
            end
            r.status = ST_FREED;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] a, status_t st);
      alloc_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat addr=%h status=%0d", a, st);
        return;
      end
      e = pending.pop_front();
      if (a !== e.addr || st !== e.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp addr=%h status=%0d, got addr=%h status=%0d",
                   e.addr, e.status, a, st);
      end
    endfunction

    // Live payload address of a random entry, or a noise address.
    function logic [31:0] pick_addr();
      if (count != 0 && $urandom_range(0, 9) < 8)
        return payload(start[$urandom_range(0, count - 1)]);
      return $urandom();
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_cmd;
  logic [20:0] in_req_size;
  logic [31:0] in_free_addr;
  logic out_valid, out_stall;
  logic [31:0] out_result_addr;
  status_t out_status;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;

  alloc_scoreboard sb;
  int idle_pct, stall_pct, quiet;
  bit timed_out;

  first_fit_heap_allocator DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random stall, check on accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_result_addr, out_status);
  end
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
  end
  always @(posedge clk) begin
    if (quiet > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(logic cmd, logic [20:0] req, logic [31:0] fa);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    in_valid <= 1; in_cmd <= cmd; in_req_size <= req; in_free_addr <= fa;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, req, fa);
    @(negedge clk);
    in_valid <= 0;
    in_cmd <= 1'($urandom()); in_req_size <= 21'($urandom()); in_free_addr <= $urandom();
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BASE_ADDRESS) sb.base = val; else sb.heap = val[20:0];
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_beat();
    int unsigned r;
    logic [20:0] sz;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      sz = 21'((r < 45) ? $urandom_range(1, 256) : $urandom_range(0, 21'h1FFFFF));
      send(CMD_ALLOC, sz, $urandom());
    end else send(CMD_FREE, 21'($urandom()), sb.pick_addr());
  endtask

  initial begin
    sb = new();
    sb.clear();
    idle_pct = 0; stall_pct = 0;
    in_valid = 0; in_cmd = 0; in_req_size = 0; in_free_addr = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    rst_n = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: zero size, rounding, reuse, coalesce, double free, null/unknown.
    send(CMD_ALLOC, 0, 0);
    send(CMD_ALLOC, 1, 0);
    send(CMD_ALLOC, 8, 0);
    send(CMD_ALLOC, 9, 0);
    send(CMD_FREE, 0, 32'd16);
    send(CMD_FREE, 0, 32'd16);
    send(CMD_FREE, 0, 32'd40);
    send(CMD_ALLOC, 8, 0);
    send(CMD_FREE, 0, 0);
    send(CMD_FREE, 0, 32'hFFFF_FFFF);
    send(CMD_ALLOC, 21'h1FFFFF, 0);
    send(CMD_ALLOC, 21'd1048576, 0);
    send(CMD_ALLOC, 21'd1048560, 0);
    drain();
    // Address wrap to zero, tiny region.
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFF0 - sb.bump);
    send(CMD_ALLOC, 4, 0);
    send(CMD_ALLOC, 4, 0);
    drain();
    write_reg(CFG_HEAP_BYTES, 0);
    send(CMD_ALLOC, 8, 0);
    send(CMD_FREE, 0, 32'h0);
    drain();
    write_reg(CFG_HEAP_BYTES, 32'h1FFFFF);
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
    // Fill the table to hit table full.
    repeat (70) send(CMD_ALLOC, 8, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      // Per phase: move the heap to a new random base address and set a new heap size.
      write_reg(CFG_BASE_ADDRESS, $urandom());
      write_reg(CFG_HEAP_BYTES, (ph == 7) ? 32'd0 : (ph == 6) ? 32'd1048576 :
                $urandom_range(sb.bump, sb.bump + 8192));
      repeat (250) begin
        random_beat();
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
test/first_fit_heap_allocator_tb.sv
